// File: src/tmqw_pkg.sv
// ----------------------------------------------------------------------------
// tmqw_pkg
// Types and constants shared by the transmit message queue blocks.
// ----------------------------------------------------------------------------
package tmqw_pkg;

	// byte ring geometry, fixed by the 12-bit chunk address
	localparam int STORE_BYTES = 4096;
	localparam int RING_AW     = 12;
	localparam int LEN_W       = 13;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK   = 2'd2;

	// register reset values
	localparam logic [LEN_W-1:0] CHUNK_SIZE_RST = 13'd1024;
	localparam logic [LEN_W-1:0] HIGH_MARK_RST  = 13'd3072;
	localparam logic [LEN_W-1:0] LOW_MARK_RST   = 13'd1024;

	typedef enum logic [1:0] {
		OP_APPEND   = 2'd0,
		OP_TRIGGER  = 2'd1,
		OP_COMPLETE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_RING_FULL  = 3'd1,
		ERR_QUEUE_FULL = 3'd2,
		ERR_PENDING    = 3'd3,
		ERR_EMPTY      = 3'd4,
		ERR_MISMATCH   = 3'd5
	} err_t;

	typedef struct packed {
		op_t              operation;
		logic [7:0]       data_byte;
		logic             end_of_message;
		logic [LEN_W-1:0] wrote_count;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic               start_write;
		logic [RING_AW-1:0] chunk_address;
		logic [LEN_W-1:0]   chunk_length;
		logic               sender_released;
		logic               more_queued;
		logic               blocked;
		err_t               status_code;
	} result_t;

endpackage

// File: src/tmqw_ram.sv
// ----------------------------------------------------------------------------
// tmqw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmqw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/tmqw_head_buf.sv
// ----------------------------------------------------------------------------
// tmqw_head_buf
// Message length queue with a read port that always tracks the next head,
// plus a bypass for a length written to that same entry.
// ----------------------------------------------------------------------------
module tmqw_head_buf
	import tmqw_pkg::*;
#(
	parameter int MAX_MESSAGES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            len_we,
	input  logic [$clog2(MAX_MESSAGES)-1:0] len_waddr,
	input  logic [LEN_W-1:0]                len_wdata,
	input  logic [$clog2(MAX_MESSAGES)-1:0] len_raddr,
	output logic [LEN_W-1:0]                head_len
);

	logic [LEN_W-1:0] ram_rdata;
	logic             fwd_hit_q;
	logic [LEN_W-1:0] fwd_data_q;

	tmqw_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_MESSAGES)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (ram_rdata)
	);

	// ram returns old data on a same-address write, so keep the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= len_we && (len_waddr == len_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= len_wdata;
	end

	assign head_len = fwd_hit_q ? fwd_data_q : ram_rdata;

endmodule

// File: src/tmqw_ctrl.sv
// ----------------------------------------------------------------------------
// tmqw_ctrl
// Queue pointers, byte counters and flow control; executes one item in the
// cycle it is taken and registers the result.
// ----------------------------------------------------------------------------
module tmqw_ctrl
	import tmqw_pkg::*;
#(
	parameter int MAX_MESSAGES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  item_t                           item,
	input  logic [LEN_W-1:0]                chunk_size,
	input  logic [LEN_W-1:0]                high_mark,
	input  logic [LEN_W-1:0]                low_mark,
	input  logic [LEN_W-1:0]                head_len,
	output logic                            len_we,
	output logic [$clog2(MAX_MESSAGES)-1:0] len_waddr,
	output logic [LEN_W-1:0]                len_wdata,
	output logic [$clog2(MAX_MESSAGES)-1:0] len_raddr,
	output logic                            ring_we,
	output logic [RING_AW-1:0]              ring_waddr,
	output logic [7:0]                      ring_wdata,
	output logic [RING_AW-1:0]              ring_head,
	output logic                            busy,
	output logic                            done,
	output result_t                         result
);

	localparam int QW = $clog2(MAX_MESSAGES);
	localparam int CW = $clog2(MAX_MESSAGES + 1);
	localparam int UW = LEN_W + 2;

	logic               busy_q;
	logic               done_q;
	result_t            result_q;

	logic [RING_AW-1:0] ring_head_q, ring_head_d;
	logic [RING_AW-1:0] ring_tail_q, ring_tail_d;
	logic [QW-1:0]      queue_head_q, queue_head_d;
	logic [QW-1:0]      queue_tail_q, queue_tail_d;
	logic [CW-1:0]      count_q, count_d;
	logic [LEN_W-1:0]   partial_q, partial_d;
	logic [LEN_W-1:0]   head_off_q, head_off_d;
	logic [LEN_W-1:0]   pending_q, pending_d;
	logic [LEN_W-1:0]   unsent_q, unsent_d;
	logic               blocked_q, blocked_d;

	logic               accept;
	logic [UW-1:0]      used;
	logic [LEN_W-1:0]   partial_inc;
	logic [LEN_W-1:0]   unsent_sum;
	logic [LEN_W-1:0]   rem;
	logic [LEN_W-1:0]   cs;
	logic [LEN_W-1:0]   clen;
	logic [LEN_W:0]     advance;
	logic [LEN_W-1:0]   unsent_left;
	logic [QW-1:0]      queue_head_inc;
	logic [QW-1:0]      queue_tail_inc;
	result_t            res;

	assign accept = start && !busy_q;

	assign used        = UW'(unsent_q) + UW'(head_off_q) + UW'(partial_q);
	assign partial_inc = partial_q + 1'b1;
	assign unsent_sum  = unsent_q + partial_inc;
	assign rem         = (head_len > head_off_q) ? head_len - head_off_q : '0;
	assign cs          = (chunk_size == '0) ? LEN_W'(1) : chunk_size;
	assign clen        = (cs < rem) ? cs : rem;
	assign advance     = (LEN_W + 1)'(head_off_q) + (LEN_W + 1)'(item.wrote_count);
	assign unsent_left = (unsent_q > item.wrote_count) ? unsent_q - item.wrote_count : '0;

	assign queue_head_inc = (queue_head_q == QW'(MAX_MESSAGES - 1)) ? '0 : queue_head_q + 1'b1;
	assign queue_tail_inc = (queue_tail_q == QW'(MAX_MESSAGES - 1)) ? '0 : queue_tail_q + 1'b1;

	always_comb begin
		ring_head_d  = ring_head_q;
		ring_tail_d  = ring_tail_q;
		queue_head_d = queue_head_q;
		queue_tail_d = queue_tail_q;
		count_d      = count_q;
		partial_d    = partial_q;
		head_off_d   = head_off_q;
		pending_d    = pending_q;
		unsent_d     = unsent_q;
		blocked_d    = blocked_q;
		len_we       = 1'b0;
		ring_we      = 1'b0;
		res          = '0;
		res.status_code = ERR_OK;

		if (accept) begin
			unique case (item.operation)
				OP_APPEND: begin
					if (item.end_of_message && (count_q >= CW'(MAX_MESSAGES))) begin
						res.status_code = ERR_QUEUE_FULL;
					end else if (used >= UW'(STORE_BYTES)) begin
						res.status_code = ERR_RING_FULL;
					end else begin
						ring_we     = 1'b1;
						ring_tail_d = ring_tail_q + 1'b1;
						partial_d   = partial_inc;
						if (item.end_of_message) begin
							res.start_write = (count_q == '0);
							len_we          = 1'b1;
							queue_tail_d    = queue_tail_inc;
							count_d         = count_q + 1'b1;
							unsent_d        = unsent_sum;
							partial_d       = '0;
							if (unsent_sum > high_mark) begin
								blocked_d = 1'b1;
							end else begin
								res.accepted = 1'b1;
							end
						end
					end
				end
				OP_TRIGGER: begin
					if (pending_q != '0) begin
						res.status_code = ERR_PENDING;
					end else if (count_q == '0) begin
						res.status_code = ERR_EMPTY;
					end else begin
						res.chunk_length  = clen;
						res.chunk_address = ring_head_q + head_off_q[RING_AW-1:0];
						pending_d         = clen;
					end
				end
				OP_COMPLETE: begin
					if (count_q == '0) begin
						res.status_code = ERR_EMPTY;
					end else if ((pending_q == '0) || (item.wrote_count != pending_q)) begin
						res.status_code = ERR_MISMATCH;
					end else begin
						pending_d = '0;
						if (advance >= (LEN_W + 1)'(head_len)) begin
							ring_head_d  = ring_head_q + head_len[RING_AW-1:0];
							queue_head_d = queue_head_inc;
							count_d      = count_q - 1'b1;
							head_off_d   = '0;
						end else begin
							head_off_d = advance[LEN_W-1:0];
						end
						unsent_d = unsent_left;
						if (blocked_q && (unsent_left < low_mark)) begin
							blocked_d           = 1'b0;
							res.sender_released = 1'b1;
						end
						res.more_queued = (count_d != '0);
					end
				end
				default: begin
				end
			endcase
		end

		res.blocked = blocked_d;
	end

	assign len_waddr  = queue_tail_q;
	assign len_wdata  = partial_inc;
	assign len_raddr  = queue_head_d;
	assign ring_waddr = ring_tail_q;
	assign ring_wdata = item.data_byte;
	assign ring_head  = ring_head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b1;
			done_q       <= 1'b0;
			ring_head_q  <= '0;
			ring_tail_q  <= '0;
			queue_head_q <= '0;
			queue_tail_q <= '0;
			count_q      <= '0;
			partial_q    <= '0;
			head_off_q   <= '0;
			pending_q    <= '0;
			unsent_q     <= '0;
			blocked_q    <= 1'b0;
		end else begin
			busy_q       <= 1'b0;
			done_q       <= accept;
			ring_head_q  <= ring_head_d;
			ring_tail_q  <= ring_tail_d;
			queue_head_q <= queue_head_d;
			queue_tail_q <= queue_tail_d;
			count_q      <= count_d;
			partial_q    <= partial_d;
			head_off_q   <= head_off_d;
			pending_q    <= pending_d;
			unsent_q     <= unsent_d;
			blocked_q    <= blocked_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res;
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_MESSAGES))
		else $error("message count beyond queue depth");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= UW'(STORE_BYTES))
		else $error("byte occupancy beyond ring size");

	a_pending_needs_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != '0) |-> (count_q != '0))
		else $error("outstanding chunk with empty queue");

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done_q)
		else $error("accepted item produced no result");

	a_release_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(blocked_q) |-> $past(accept && (item.operation == OP_COMPLETE)))
		else $error("sender released outside a completion");

endmodule

// File: src/tx_message_queue_watermark_core.sv
// ----------------------------------------------------------------------------
// tx_message_queue_watermark_core
// Transmit message queue: byte ring, queue of message lengths, chunked
// write hand-out and high/low watermark flow control.
// ----------------------------------------------------------------------------
// result: an item taken at a clock edge has its result on the ports, done high,
//   for the cycle after that edge; the receiver cannot stall it
// throughput: one item per cycle when not busy; length queue head read ahead
//   every cycle at the next head pointer, with a bypass for a same-entry write
// reset: arst_n clears pointers, counters, flags and registers; busy is high
//   for the first cycle after reset; ring and length queue are not cleared
module tx_message_queue_watermark_core
	import tmqw_pkg::*;
#(
	parameter int MAX_MESSAGES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	output logic [7:0]           head_byte
);

	localparam int QW = $clog2(MAX_MESSAGES);

	// configuration registers
	logic [LEN_W-1:0] chunk_size_q;
	logic [LEN_W-1:0] high_mark_q;
	logic [LEN_W-1:0] low_mark_q;

	// length queue port
	logic             len_we;
	logic [QW-1:0]    len_waddr;
	logic [LEN_W-1:0] len_wdata;
	logic [QW-1:0]    len_raddr;
	logic [LEN_W-1:0] head_len;

	// byte ring port
	logic               ring_we;
	logic [RING_AW-1:0] ring_waddr;
	logic [7:0]         ring_wdata;
	logic [RING_AW-1:0] ring_head;

	// index beyond the register list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RST;
			high_mark_q  <= HIGH_MARK_RST;
			low_mark_q   <= LOW_MARK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHUNK_SIZE: chunk_size_q <= cfg_data;
				REG_HIGH_MARK:  high_mark_q  <= cfg_data;
				REG_LOW_MARK:   low_mark_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// message bytes; the sender side fetches from the head of the ring,
	// first byte of the head message shows in the cycle after the head moves
	tmqw_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_byte_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_head),
		.rdata (head_byte)
	);

	// lengths of completed messages, head entry always on hand
	tmqw_head_buf #(
		.MAX_MESSAGES(MAX_MESSAGES)
	) u_head_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.len_we    (len_we),
		.len_waddr (len_waddr),
		.len_wdata (len_wdata),
		.len_raddr (len_raddr),
		.head_len  (head_len)
	);

	// pointers, counters, watermark flag and result register
	tmqw_ctrl #(
		.MAX_MESSAGES(MAX_MESSAGES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.chunk_size (chunk_size_q),
		.high_mark  (high_mark_q),
		.low_mark   (low_mark_q),
		.head_len   (head_len),
		.len_we     (len_we),
		.len_waddr  (len_waddr),
		.len_wdata  (len_wdata),
		.len_raddr  (len_raddr),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_head  (ring_head),
		.busy       (busy),
		.done       (done),
		.result     (result)
	);

endmodule

// File: test/tx_message_queue_watermark_core_tb.sv
// ----------------------------------------------------------------------------
// tx_message_queue_watermark_core_tb
// Self-checking bench for the transmit message queue. Items are driven
// through the start/busy handshake with random gaps. A behavioral copy of
// the queue (length queue, offsets, unsent count, watermark flag) predicts
// every result, and each done strobe is checked field by field against the
// oldest prediction. A short directed table comes first, then random traffic
// under several register settings and a message queue overflow. While idle,
// the byte at the ring head is checked against a copy of the ring.
// ----------------------------------------------------------------------------
module tx_message_queue_watermark_core_tb;
	import tmqw_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	// operation code the block ignores
	localparam logic [1:0] OP_IGNORED = 2'd3;
	// items per random traffic phase
	localparam int PHASE_ITEMS = 260;

	// directed table row: expectation typed in only where obvious
	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                in_item;
	logic                 done;
	result_t              out_result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;
	logic [7:0]           head_byte;

	// expected results, oldest first
	result_t due_results[$];
	row_t    plan[$];
	int      errors = 0;

	// shadow of the queue state
	int lengths[QUEUE_DEPTH];
	logic [7:0] ring_copy[STORE_BYTES];
	int head_at   = 0;  // ring address of the head message
	int tail_at   = 0;  // next free ring address
	int lq_head   = 0;
	int lq_tail   = 0;
	int msg_cnt   = 0;
	int build_len = 0;  // bytes of the message being built
	int sent_off  = 0;  // bytes of the head message already written
	int inflight  = 0;  // length of the chunk handed out, 0 if none
	int unsent    = 0;
	bit held      = 1'b0;

	// shadow of the registers
	int chunk_cfg = int'(CHUNK_SIZE_RST);
	int high_cfg  = int'(HIGH_MARK_RST);
	int low_cfg   = int'(LOW_MARK_RST);

	// stimulus shaping
	int msg_left   = 0;  // bytes left in the message being generated
	int burst_left = 0;  // items left in a no-gap stretch

	tx_message_queue_watermark_core #(
		.MAX_MESSAGES(QUEUE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (in_item),
		.done      (done),
		.result    (out_result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head_byte (head_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest correct run
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic item_t mk_item(logic [1:0] op, logic [7:0] data, logic eom,
			logic [LEN_W-1:0] wrote);
		item_t it;
		it.operation      = op_t'(op);
		it.data_byte      = data;
		it.end_of_message = eom;
		it.wrote_count    = wrote;
		return it;
	endfunction

	function automatic result_t mk_res(logic acc, logic sw, logic blk, err_t err);
		result_t r;
		r             = '0;
		r.accepted    = acc;
		r.start_write = sw;
		r.blocked     = blk;
		r.status_code = err;
		return r;
	endfunction

	function automatic void plan_row(item_t it, bit typed, result_t want);
		row_t r;
		r.it    = it;
		r.typed = typed;
		r.want  = want;
		plan.insert(plan.size(), r);
	endfunction

	// applies one accepted item to the shadow state and returns its result
	function automatic result_t advance_queue(item_t it);
		result_t r;
		int used;
		int len;
		int rem;
		int step;
		int wrote;
		r     = '0;
		wrote = int'(it.wrote_count);
		case (it.operation)
			OP_APPEND: begin
				used = unsent + sent_off + build_len;
				// a full length queue only matters for the closing byte
				if (it.end_of_message && msg_cnt >= QUEUE_DEPTH) begin
					r.status_code = ERR_QUEUE_FULL;
				end else if (used >= STORE_BYTES) begin
					r.status_code = ERR_RING_FULL;
				end else begin
					ring_copy[tail_at] = it.data_byte;
					tail_at = (tail_at + 1) % STORE_BYTES;
					build_len++;
					if (it.end_of_message) begin
						r.start_write = (msg_cnt == 0);
						lengths[lq_tail] = build_len;
						lq_tail = (lq_tail + 1) % QUEUE_DEPTH;
						msg_cnt++;
						unsent += build_len;
						build_len = 0;
						// over the high mark: still queued, but not accepted
						if (unsent > high_cfg) begin
							held = 1'b1;
						end else begin
							r.accepted = 1'b1;
						end
					end
				end
			end
			OP_TRIGGER: begin
				if (inflight != 0) begin
					r.status_code = ERR_PENDING;
				end else if (msg_cnt == 0) begin
					r.status_code = ERR_EMPTY;
				end else begin
					len  = lengths[lq_head];
					rem  = (len > sent_off) ? len - sent_off : 0;
					// a zero chunk size behaves as one byte
					step = (chunk_cfg == 0) ? 1 : chunk_cfg;
					inflight = (step < rem) ? step : rem;
					r.chunk_address = RING_AW'((head_at + sent_off) % STORE_BYTES);
					r.chunk_length  = LEN_W'(inflight);
				end
			end
			OP_COMPLETE: begin
				if (msg_cnt == 0) begin
					r.status_code = ERR_EMPTY;
				end else if (inflight == 0 || wrote != inflight) begin
					r.status_code = ERR_MISMATCH;
				end else begin
					len = lengths[lq_head];
					inflight = 0;
					if (sent_off + wrote >= len) begin
						head_at = (head_at + len) % STORE_BYTES;
						lq_head = (lq_head + 1) % QUEUE_DEPTH;
						msg_cnt--;
						sent_off = 0;
					end else begin
						sent_off += wrote;
					end
					unsent = (unsent > wrote) ? unsent - wrote : 0;
					// release only a blocked sender, and only under the low mark
					if (held && unsent < low_cfg) begin
						held = 1'b0;
						r.sender_released = 1'b1;
					end
					r.more_queued = (msg_cnt != 0);
				end
			end
			default: begin
			end
		endcase
		r.blocked = held;
		return r;
	endfunction

	// idle cycles before the next item, with stretches of back-to-back items
	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = int'($urandom_range(10, 60));
			return 0;
		end
		return int'($urandom_range(0, 14));
	endfunction

	// mostly well-formed traffic: messages, triggers and matching completions
	function automatic item_t random_item();
		int         k;
		logic [7:0] data;
		logic       eom;
		logic [LEN_W-1:0] wrote;
		k     = int'($urandom_range(0, 99));
		data  = 8'($urandom_range(0, 255));
		eom   = 1'($urandom_range(0, 1));
		wrote = LEN_W'($urandom_range(0, STORE_BYTES));
		if (k < 55) begin
			// long messages only where chunks are large enough to drain them
			if (msg_left == 0) begin
				if (chunk_cfg >= 64 && $urandom_range(0, 7) == 0) begin
					msg_left = int'($urandom_range(64, 700));
				end else begin
					msg_left = int'($urandom_range(1, 12));
				end
			end
			eom = (msg_left == 1);
			msg_left--;
			return mk_item(OP_APPEND, data, eom, wrote);
		end
		if (k < 75) begin
			return mk_item(OP_TRIGGER, data, eom, wrote);
		end
		if (k < 95) begin
			if (inflight != 0) begin
				wrote = LEN_W'(inflight);
			end
			return mk_item(OP_COMPLETE, data, eom, wrote);
		end
		// noise: completions with a random count and ignored operations
		if (k < 98) begin
			return mk_item(OP_COMPLETE, data, eom, wrote);
		end
		return mk_item(OP_IGNORED, data, eom, wrote);
	endfunction

	function automatic int check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// one item through the handshake; prediction is made at the accepting edge
	task automatic issue(item_t it, bit typed, result_t want);
		int      gap;
		result_t predicted;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		predicted = advance_queue(it);
		due_results.insert(due_results.size(), typed ? want : predicted);
	endtask

	// stop driving and let every outstanding result come back
	task automatic wait_idle();
		start <= 1'b0;
		for (int w = 0; w < 200 && due_results.size() != 0; w++) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d results expected, none arrived", $time, due_results.size());
			errors += due_results.size();
			due_results.delete();
		end
		repeat (2) @(posedge clk);
		// first byte of the head message, read out of the ring
		if (msg_cnt != 0 && head_byte !== ring_copy[head_at]) begin
			$display("%0t: head_byte expected %0h got %0h", $time, ring_copy[head_at],
				head_byte);
			errors++;
		end
	endtask

	// all three registers, one per cycle, only while idle
	task automatic configure(int chunk, int high, int low);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CHUNK_SIZE;
		cfg_data  <= LEN_W'(chunk);
		@(posedge clk);
		cfg_index <= REG_HIGH_MARK;
		cfg_data  <= LEN_W'(high);
		@(posedge clk);
		cfg_index <= REG_LOW_MARK;
		cfg_data  <= LEN_W'(low);
		@(posedge clk);
		cfg_we    <= 1'b0;
		chunk_cfg = chunk;
		high_cfg  = high;
		low_cfg   = low;
	endtask

	// empty the queue with well-formed writes, closing any partial message
	task automatic drain_queue();
		while (msg_cnt != 0 || build_len != 0) begin
			if (inflight != 0) begin
				issue(mk_item(OP_COMPLETE, 8'($urandom_range(0, 255)), 1'b0,
					LEN_W'(inflight)), 1'b0, '0);
			end else if (msg_cnt != 0) begin
				issue(mk_item(OP_TRIGGER, 8'($urandom_range(0, 255)), 1'b0,
					LEN_W'($urandom_range(0, STORE_BYTES))), 1'b0, '0);
			end else begin
				issue(mk_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b1,
					LEN_W'($urandom_range(0, STORE_BYTES))), 1'b0, '0);
			end
		end
		msg_left = 0;
	endtask

	// every done strobe is matched against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (due_results.size() == 0) begin
				$display("%0t: result expected none got %p", $time, out_result);
				errors++;
			end else begin
				want = due_results[0];
				due_results.delete(0);
				errors += check_field("accepted", 16'(want.accepted),
					16'(out_result.accepted));
				errors += check_field("start_write", 16'(want.start_write),
					16'(out_result.start_write));
				errors += check_field("chunk_address", 16'(want.chunk_address),
					16'(out_result.chunk_address));
				errors += check_field("chunk_length", 16'(want.chunk_length),
					16'(out_result.chunk_length));
				errors += check_field("sender_released", 16'(want.sender_released),
					16'(out_result.sender_released));
				errors += check_field("more_queued", 16'(want.more_queued),
					16'(out_result.more_queued));
				errors += check_field("blocked", 16'(want.blocked),
					16'(out_result.blocked));
				errors += check_field("status_code", 16'(want.status_code),
					16'(out_result.status_code));
			end
		end
	end

	initial begin : stimulus
		// every input known from time zero
		arst_n    <= 1'b0;
		start     <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_CHUNK_SIZE;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);

		// directed: zero chunk size, tiny marks so blocking shows at once
		configure(0, 2, 1);
		// nothing queued yet
		plan_row(mk_item(OP_TRIGGER, 8'h00, 1'b0, 13'd0), 1'b1,
			mk_res(1'b0, 1'b0, 1'b0, ERR_EMPTY));
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd4096), 1'b1,
			mk_res(1'b0, 1'b0, 1'b0, ERR_EMPTY));
		plan_row(mk_item(OP_IGNORED, 8'hFF, 1'b1, 13'd4096), 1'b1,
			mk_res(1'b0, 1'b0, 1'b0, ERR_OK));
		// two-byte message into an empty queue, at the high mark exactly
		plan_row(mk_item(OP_APPEND, 8'h00, 1'b0, 13'd0), 1'b1,
			mk_res(1'b0, 1'b0, 1'b0, ERR_OK));
		plan_row(mk_item(OP_APPEND, 8'hFF, 1'b1, 13'd4096), 1'b1,
			mk_res(1'b1, 1'b1, 1'b0, ERR_OK));
		// one more byte goes over the high mark
		plan_row(mk_item(OP_APPEND, 8'hA5, 1'b1, 13'd0), 1'b1,
			mk_res(1'b0, 1'b0, 1'b1, ERR_OK));
		// completion with no write outstanding
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd1), 1'b1,
			mk_res(1'b0, 1'b0, 1'b1, ERR_MISMATCH));
		plan_row(mk_item(OP_TRIGGER, 8'h00, 1'b0, 13'd0), 1'b0, '0);
		// second trigger while the first write is outstanding
		plan_row(mk_item(OP_TRIGGER, 8'h00, 1'b0, 13'd0), 1'b1,
			mk_res(1'b0, 1'b0, 1'b1, ERR_PENDING));
		// wrong count
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd2), 1'b1,
			mk_res(1'b0, 1'b0, 1'b1, ERR_MISMATCH));
		// byte-sized chunks walk the messages, the last pop releases the sender
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd1), 1'b0, '0);
		plan_row(mk_item(OP_TRIGGER, 8'h00, 1'b0, 13'd0), 1'b0, '0);
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd1), 1'b0, '0);
		plan_row(mk_item(OP_TRIGGER, 8'h00, 1'b0, 13'd0), 1'b0, '0);
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd1), 1'b0, '0);
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd0), 1'b1,
			mk_res(1'b0, 1'b0, 1'b0, ERR_EMPTY));
		// single-byte message after the queue emptied
		plan_row(mk_item(OP_APPEND, 8'h5A, 1'b1, 13'd0), 1'b1,
			mk_res(1'b1, 1'b1, 1'b0, ERR_OK));
		plan_row(mk_item(OP_TRIGGER, 8'h00, 1'b0, 13'd0), 1'b0, '0);
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd0), 1'b1,
			mk_res(1'b0, 1'b0, 1'b0, ERR_MISMATCH));
		plan_row(mk_item(OP_COMPLETE, 8'h00, 1'b0, 13'd1), 1'b0, '0);
		foreach (plan[i]) begin
			issue(plan[i].it, plan[i].typed, plan[i].want);
		end

		// random traffic under extreme, default and random settings
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			case (p)
				0: configure(4096, 4096, 0);
				1: configure(1, 0, 4096);
				2: configure(int'(CHUNK_SIZE_RST), int'(HIGH_MARK_RST), int'(LOW_MARK_RST));
				default: configure(int'($urandom_range(0, 4096)),
					int'($urandom_range(0, 200)), int'($urandom_range(0, 200)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				issue(random_item(), 1'b0, '0);
			end
		end

		// message queue overflow: one-byte messages until every slot is taken
		wait_idle();
		configure(4096, 4096, 0);
		drain_queue();
		wait_idle();
		configure(1, 10, 5);
		for (int n = 0; n < QUEUE_DEPTH + 1; n++) begin
			issue(mk_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b1, 13'd0), 1'b0, '0);
		end
		// a plain byte still fits, its closing byte does not
		issue(mk_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0, 13'd0), 1'b0, '0);
		issue(mk_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b1, 13'd0), 1'b0, '0);
		drain_queue();

		wait_idle();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
src/tmqw_pkg.sv
src/tmqw_ram.sv
src/tmqw_head_buf.sv
src/tmqw_ctrl.sv
src/tx_message_queue_watermark_core.sv
test/tx_message_queue_watermark_core_tb.sv
